[hdl/button_click_event_detector_core_macros.svh]
// Assertion macros used by the button click event detector checker.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_CORE_MACROS_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_CORE_MACROS_SVH

// Check a property outside reset.
`define BCED_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define BCED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/bced_pkg.sv]
// Package with phase codes, event codes and configuration types of the click detector.
package bced_pkg;

  localparam int unsigned StampW = 32;
  localparam int unsigned ThrW   = 16;
  localparam int unsigned EventW = 3;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PhaseW-1:0] PH_IDLE      = 3'd0;
  localparam logic [PhaseW-1:0] PH_DEB_PRESS = 3'd1;
  localparam logic [PhaseW-1:0] PH_PRESSED   = 3'd2;
  localparam logic [PhaseW-1:0] PH_WAIT_DBL  = 3'd3;
  localparam logic [PhaseW-1:0] PH_DEB_SEC   = 3'd4;
  localparam logic [PhaseW-1:0] PH_CONSUME   = 3'd5;
  localparam logic [PhaseW-1:0] PH_HOLD      = 3'd6;
  localparam logic [PhaseW-1:0] PH_DEB_REL   = 3'd7;

  localparam logic [EventW-1:0] EV_NONE     = 3'd0;
  localparam logic [EventW-1:0] EV_PRESSED  = 3'd1;
  localparam logic [EventW-1:0] EV_LONG     = 3'd2;
  localparam logic [EventW-1:0] EV_SINGLE   = 3'd3;
  localparam logic [EventW-1:0] EV_DOUBLE   = 3'd4;
  localparam logic [EventW-1:0] EV_REPEAT   = 3'd5;
  localparam logic [EventW-1:0] EV_RELEASED = 3'd6;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DBL_WAIT   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT     = 2'd3;

  localparam logic [ThrW-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [ThrW-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [ThrW-1:0] DBL_WAIT_RST   = 16'd300;
  localparam logic [ThrW-1:0] REPEAT_RST     = 16'd200;

  typedef struct packed {
    logic [ThrW-1:0] debounce_ms;
    logic [ThrW-1:0] long_press_ms;
    logic [ThrW-1:0] double_click_wait_ms;
    logic [ThrW-1:0] repeat_interval_ms;
  } bced_cfg_t;

endpackage

[hdl/bced_engine.sv]
// Phase machine and timestamp registers that turn button samples into events.
module bced_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          pressed_i,
  input  logic [bced_pkg::StampW-1:0]   now_ms_i,
  input  bced_pkg::bced_cfg_t           cfg_i,
  output logic [bced_pkg::EventW-1:0]   event_code_o
);
  import bced_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [StampW-1:0] change_q, change_d;
  logic [StampW-1:0] repeat_q, repeat_d;
  logic [StampW-1:0] since, since_rep;
  logic              deb_met, long_met, wait_met, rep_met;

  assign since     = now_ms_i - change_q;
  assign since_rep = now_ms_i - repeat_q;
  assign deb_met   = since >= {{(StampW-ThrW){1'b0}}, cfg_i.debounce_ms};
  assign long_met  = since >= {{(StampW-ThrW){1'b0}}, cfg_i.long_press_ms};
  assign wait_met  = since >= {{(StampW-ThrW){1'b0}}, cfg_i.double_click_wait_ms};
  assign rep_met   = since_rep >= {{(StampW-ThrW){1'b0}}, cfg_i.repeat_interval_ms};

  always_comb begin
    phase_d      = phase_q;
    change_d     = change_q;
    repeat_d     = repeat_q;
    event_code_o = EV_NONE;
    unique case (phase_q)
      PH_IDLE: begin
        if (pressed_i) begin
          phase_d  = PH_DEB_PRESS;
          change_d = now_ms_i;
        end
      end
      PH_DEB_PRESS: begin
        if (deb_met) begin
          if (pressed_i) begin
            phase_d      = PH_PRESSED;
            change_d     = now_ms_i;
            event_code_o = EV_PRESSED;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (!pressed_i) begin
          phase_d  = PH_WAIT_DBL;
          change_d = now_ms_i;
        end else if (long_met) begin
          phase_d      = PH_HOLD;
          repeat_d     = now_ms_i;
          event_code_o = EV_LONG;
        end
      end
      PH_WAIT_DBL: begin
        if (pressed_i) begin
          phase_d  = PH_DEB_SEC;
          change_d = now_ms_i;
        end else if (wait_met) begin
          phase_d      = PH_IDLE;
          event_code_o = EV_SINGLE;
        end
      end
      PH_DEB_SEC: begin
        if (deb_met) begin
          if (pressed_i) begin
            phase_d      = PH_CONSUME;
            event_code_o = EV_DOUBLE;
          end else begin
            phase_d  = PH_WAIT_DBL;
            change_d = now_ms_i;
          end
        end
      end
      PH_CONSUME: begin
        if (!pressed_i) begin
          phase_d = PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (!pressed_i) begin
          phase_d  = PH_DEB_REL;
          change_d = now_ms_i;
        end else if (rep_met) begin
          repeat_d     = now_ms_i;
          event_code_o = EV_REPEAT;
        end
      end
      default: begin
        if (deb_met) begin
          if (!pressed_i) begin
            phase_d      = PH_IDLE;
            event_code_o = EV_RELEASED;
          end else begin
            phase_d  = PH_HOLD;
            repeat_d = now_ms_i;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      change_q <= '0;
      repeat_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      change_q <= change_d;
      repeat_q <= repeat_d;
    end
  end

endmodule

[hdl/button_click_event_detector_core.sv]
// Top level of the button click event detector: sample register, engine, result register.
// A sample waits in the sample register; its event is registered once the output can advance.
// Throughput: one sample per cycle; a stalled result holds the sample register, then the input.
// Each sample is evaluated combinationally by two 32-bit subtracts and a compare per threshold.
// Reset: phase idle, both timestamps zero, thresholds 20/1000/300/200 ms, pipeline empty.
module button_click_event_detector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           pressed_i,
  input  logic [bced_pkg::StampW-1:0]    now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bced_pkg::EventW-1:0]    event_code_o,
  input  logic                           cfg_we_i,
  input  logic [bced_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bced_pkg::ThrW-1:0]      cfg_wdata_i
);
  import bced_pkg::*;

  bced_cfg_t         cfg_q;
  logic              smp_valid_q;
  logic              smp_pressed_q;
  logic [StampW-1:0] smp_now_q;
  logic              out_valid_q;
  logic [EventW-1:0] event_q, event_d;
  logic              advance;
  logic              step;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = smp_valid_q && advance;
  assign in_ready_o = !smp_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms          <= DEBOUNCE_RST;
      cfg_q.long_press_ms        <= LONG_PRESS_RST;
      cfg_q.double_click_wait_ms <= DBL_WAIT_RST;
      cfg_q.repeat_interval_ms   <= REPEAT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:   cfg_q.debounce_ms          <= cfg_wdata_i;
        CFG_LONG_PRESS: cfg_q.long_press_ms        <= cfg_wdata_i;
        CFG_DBL_WAIT:   cfg_q.double_click_wait_ms <= cfg_wdata_i;
        CFG_REPEAT:     cfg_q.repeat_interval_ms   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      smp_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_pressed_q <= pressed_i;
      smp_now_q     <= now_ms_i;
    end
  end

  bced_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .pressed_i    (smp_pressed_q),
    .now_ms_i     (smp_now_q),
    .cfg_i        (cfg_q),
    .event_code_o (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= smp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      event_q <= event_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;

endmodule

[hdl/bced_checker.sv]
// Port-level checker for the button click event detector, bound to the top level.
`include "button_click_event_detector_core_macros.svh"

module bced_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bced_pkg::EventW-1:0]   event_code_o
);
  import bced_pkg::*;

  `BCED_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !out_valid_o, "result valid after reset")
  `BCED_ASSERT(a_ready_when_drained, clk_i, rst_ni, out_ready_i |-> in_ready_o, "input stalled while output drains")
  `BCED_ASSERT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_code_o), "stalled result changed")
  `BCED_ASSERT(a_event_code_legal, clk_i, rst_ni, out_valid_o |-> event_code_o <= EV_RELEASED, "illegal event code")

endmodule

bind button_click_event_detector_core bced_checker u_bced_checker (.*);

[dv/tb_button_click_event_detector_core.sv]
// Self-checking testbench for the button click event detector core.
`timescale 1ns / 100ps

module tb_button_click_event_detector_core;
  import bced_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF_LEN = 150;

  typedef struct packed {
    logic              level;
    logic [StampW-1:0] stamp;
    logic              typed;
    logic [EventW-1:0] code;
  } sample_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                pressed_i = 1'b0;
  logic [StampW-1:0]   now_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [EventW-1:0]   event_code_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_DEBOUNCE;
  logic [ThrW-1:0]     cfg_wdata_i = '0;

  button_click_event_detector_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pressed_i    (pressed_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Detector state tracked alongside the block
  bced_cfg_t          thr;
  logic [PhaseW-1:0]  trk_phase;
  logic [StampW-1:0]  change_ts;
  logic [StampW-1:0]  repeat_ts;

  logic [EventW-1:0]  pending_events[$];
  logic [StampW-1:0]  clock_ms;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 errors;
  int                 cycle_cnt;
  int                 hold_left;
  logic               hold_armed;
  logic               hold_done;

  sample_row_t directed_rows[25] = '{
    '{1'b0, 32'd0,          1'b1, EV_NONE},
    '{1'b1, 32'd5,          1'b0, EV_NONE},
    '{1'b1, 32'd24,         1'b0, EV_NONE},
    '{1'b1, 32'd25,         1'b0, EV_NONE},
    '{1'b0, 32'd100,        1'b0, EV_NONE},
    '{1'b0, 32'd400,        1'b0, EV_NONE},
    '{1'b1, 32'd500,        1'b0, EV_NONE},
    '{1'b1, 32'd520,        1'b0, EV_NONE},
    '{1'b0, 32'd600,        1'b0, EV_NONE},
    '{1'b1, 32'd650,        1'b0, EV_NONE},
    '{1'b0, 32'd660,        1'b0, EV_NONE},
    '{1'b0, 32'd670,        1'b0, EV_NONE},
    '{1'b1, 32'd700,        1'b0, EV_NONE},
    '{1'b1, 32'd720,        1'b0, EV_NONE},
    '{1'b1, 32'd800,        1'b0, EV_NONE},
    '{1'b0, 32'd810,        1'b0, EV_NONE},
    '{1'b1, 32'hFFFF_FFF0,  1'b1, EV_NONE},
    '{1'b1, 32'h0000_0004,  1'b1, EV_PRESSED},
    '{1'b1, 32'd1004,       1'b0, EV_NONE},
    '{1'b1, 32'd1204,       1'b0, EV_NONE},
    '{1'b0, 32'd1300,       1'b0, EV_NONE},
    '{1'b1, 32'd1310,       1'b0, EV_NONE},
    '{1'b1, 32'd1320,       1'b0, EV_NONE},
    '{1'b0, 32'd1400,       1'b0, EV_NONE},
    '{1'b0, 32'd1420,       1'b0, EV_NONE}
  };

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [EventW-1:0] next_click_event(input logic level,
                                                         input logic [StampW-1:0] now);
    logic [StampW-1:0] since;
    logic [EventW-1:0] ev;
    since = now - change_ts;
    ev    = EV_NONE;
    case (trk_phase)
      PH_IDLE: begin
        if (level) begin
          trk_phase = PH_DEB_PRESS;
          change_ts = now;
        end
      end
      PH_DEB_PRESS: begin
        if (since >= thr.debounce_ms) begin
          if (level) begin
            trk_phase = PH_PRESSED;
            change_ts = now;
            ev        = EV_PRESSED;
          end else begin
            trk_phase = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (!level) begin
          trk_phase = PH_WAIT_DBL;
          change_ts = now;
        end else if (since >= thr.long_press_ms) begin
          trk_phase = PH_HOLD;
          repeat_ts = now;
          ev        = EV_LONG;
        end
      end
      PH_WAIT_DBL: begin
        if (level) begin
          trk_phase = PH_DEB_SEC;
          change_ts = now;
        end else if (since >= thr.double_click_wait_ms) begin
          trk_phase = PH_IDLE;
          ev        = EV_SINGLE;
        end
      end
      PH_DEB_SEC: begin
        if (since >= thr.debounce_ms) begin
          if (level) begin
            trk_phase = PH_CONSUME;
            ev        = EV_DOUBLE;
          end else begin
            trk_phase = PH_WAIT_DBL;
            change_ts = now;
          end
        end
      end
      PH_CONSUME: begin
        if (!level) trk_phase = PH_IDLE;
      end
      PH_HOLD: begin
        if (!level) begin
          trk_phase = PH_DEB_REL;
          change_ts = now;
        end else if ((now - repeat_ts) >= thr.repeat_interval_ms) begin
          repeat_ts = now;
          ev        = EV_REPEAT;
        end
      end
      default: begin
        if (since >= thr.debounce_ms) begin
          if (!level) begin
            trk_phase = PH_IDLE;
            ev        = EV_RELEASED;
          end else begin
            trk_phase = PH_HOLD;
            repeat_ts = now;
          end
        end
      end
    endcase
    return ev;
  endfunction

  task automatic send_sample(input logic level, input logic [StampW-1:0] now,
                             input logic typed, input logic [EventW-1:0] code);
    logic [EventW-1:0] ev;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pressed_i  <= level;
    now_ms_i   <= now;
    do @(posedge clk_i); while (!in_ready_o);
    ev = next_click_event(level, now);
    pending_events.push_back(typed ? code : ev);
    clock_ms = now;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ThrW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic program_thresholds(input bced_cfg_t c);
    write_reg(CFG_DEBOUNCE,   c.debounce_ms);
    write_reg(CFG_LONG_PRESS, c.long_press_ms);
    write_reg(CFG_DBL_WAIT,   c.double_click_wait_ms);
    write_reg(CFG_REPEAT,     c.repeat_interval_ms);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr = c;
  endtask

  // Runs of one level with occasional bounces, timestamp jumps and stalls in time
  task automatic run_random(input int count);
    logic        level;
    int          run_left;
    int          scale;
    int          pick;
    int          r;
    logic [StampW-1:0] now;
    level    = 1'b0;
    run_left = 0;
    scale    = 4;
    now      = clock_ms;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        level    = ($urandom_range(0, 9) < 8) ? ~level : level;
        run_left = $urandom_range(1, 8);
        pick     = $urandom_range(0, 3);
        case (pick)
          0:       scale = int'(thr.debounce_ms) / 2 + 3;
          1:       scale = int'(thr.long_press_ms) / 2 + 3;
          2:       scale = int'(thr.double_click_wait_ms) / 2 + 3;
          default: scale = int'(thr.repeat_interval_ms) / 2 + 3;
        endcase
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (r < 5) now = $urandom;
      else if (r >= 15) now = now + $urandom_range(0, scale);
      send_sample(($urandom_range(0, 99) < 10) ? ~level : level, now, 1'b0, EV_NONE);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_armed && !hold_done) begin
      hold_left = HOLD_OFF_LEN;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    logic [EventW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event_code, expected none, actual %0d", $time, event_code_o);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (event_code_o !== want) begin
          $display("%0t: event_code mismatch, expected %0d, actual %0d",
                   $time, want, event_code_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[button_click_event_detector_core] ERROR");
      $finish;
    end
  end

  initial begin
    bced_cfg_t c;
    thr         = '{DEBOUNCE_RST, LONG_PRESS_RST, DBL_WAIT_RST, REPEAT_RST};
    trk_phase   = PH_IDLE;
    change_ts   = '0;
    repeat_ts   = '0;
    clock_ms    = '0;
    errors      = 0;
    cycle_cnt   = 0;
    hold_left   = 0;
    hold_armed  = 1'b0;
    hold_done   = 1'b0;
    tx_idle_pct = 12;
    rx_idle_pct = 52;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].level, directed_rows[i].stamp,
                  directed_rows[i].typed, directed_rows[i].code);
    run_random(150);

    // zero thresholds: met on the very next sample
    settle();
    program_thresholds('{16'd0, 16'd0, 16'd0, 16'd0});
    run_random(150);

    tx_idle_pct = 52;
    rx_idle_pct = 12;
    settle();
    program_thresholds('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_random(150);

    settle();
    c.debounce_ms          = ThrW'($urandom_range(0, 50));
    c.long_press_ms        = ThrW'($urandom_range(0, 50));
    c.double_click_wait_ms = ThrW'($urandom_range(0, 50));
    c.repeat_interval_ms   = ThrW'($urandom_range(0, 50));
    program_thresholds(c);
    run_random(250);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    settle();
    c.debounce_ms          = ThrW'($urandom_range(0, 200));
    c.long_press_ms        = ThrW'($urandom_range(0, 3000));
    c.double_click_wait_ms = ThrW'($urandom_range(0, 3000));
    c.repeat_interval_ms   = ThrW'($urandom_range(0, 3000));
    program_thresholds(c);
    run_random(20);
    hold_armed = 1'b1;
    run_random(130);

    settle();
    program_thresholds('{DEBOUNCE_RST, LONG_PRESS_RST, DBL_WAIT_RST, REPEAT_RST});
    run_random(150);

    settle();
    if (errors == 0) begin
      $display("[button_click_event_detector_core] OK");
    end else begin
      $display("[button_click_event_detector_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/bced_pkg.sv
hdl/bced_engine.sv
hdl/button_click_event_detector_core.sv
hdl/bced_checker.sv
dv/tb_button_click_event_detector_core.sv
